// ----- rtl/core/swm_pkg.sv -----
package swm_pkg;

  localparam int WINDOW = 16;
  localparam int VAL_W  = 32;
  localparam int MED_W  = VAL_W + 1;
  localparam int CNT_W  = 5;
  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [MED_W-1:0]  med_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_NOT_FOUND = 2'd1,
    ERR_FULL      = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_MED_LO,
    ST_MED_HI,
    ST_MED_SUM
  } state_t;

endpackage

// ----- rtl/core/swm_if.sv -----
interface swm_in_if;
  logic             valid;
  logic             ready;
  swm_pkg::val_t    new_value;
  swm_pkg::val_t    old_value;
  logic             old_present;

  modport source (output valid, output new_value, output old_value, output old_present,
                  input ready);
  modport sink   (input valid, input new_value, input old_value, input old_present,
                  output ready);
endinterface

interface swm_out_if;
  logic             valid;
  logic             ready;
  swm_pkg::med_t    median_value;
  swm_pkg::cnt_t    stored_count;
  logic [1:0]       error_code;

  modport source (output valid, output median_value, output stored_count,
                  output error_code, input ready);
  modport sink   (input valid, input median_value, input stored_count,
                  input error_code, output ready);
endinterface

// ----- rtl/core/swm_ram.sv -----
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/sliding_window_median.sv -----
// A request accepted in ST_IDLE goes through a remove walk over the N samples held (when an
// old value is present), an insert walk (when the new value is to be added), and then the
// median states ST_MED_LO, ST_MED_HI and ST_MED_SUM, the last of which loads the output
// register and waits there while the previous result has not been taken.
// A new request is taken only once the previous one is done and the block is back in ST_IDLE;
// the walks share the single read port of the sample memory. A finished result waits in its own register.
// Reset (rst_n low, synchronous) empties the window; memory contents are kept.
module sliding_window_median (
  input  logic       clk,
  input  logic       rst_n,
  swm_in_if.sink     in_chan,
  swm_out_if.source  out_chan
);

  swm_pkg::state_t state_r, state_nxt;
  swm_pkg::cnt_t   cnt_r, cnt_nxt;
  swm_pkg::val_t   nv_r, nv_nxt;
  swm_pkg::val_t   ov_r, ov_nxt;
  swm_pkg::err_t   err_r, err_nxt;
  swm_pkg::cnt_t   rd_idx_r, rd_idx_nxt;
  logic            dvld_r, dvld_nxt;
  swm_pkg::addr_t  didx_r, didx_nxt;
  logic            found_r, found_nxt;
  logic            placed_r, placed_nxt;
  swm_pkg::val_t   carry_r, carry_nxt;
  swm_pkg::val_t   lo_r, lo_nxt;
  logic            out_valid_r, out_valid_nxt;
  swm_pkg::med_t   out_med_r, out_med_nxt;
  swm_pkg::cnt_t   out_cnt_r, out_cnt_nxt;
  swm_pkg::err_t   out_err_r, out_err_nxt;

  logic            ram_we, ram_re;
  swm_pkg::addr_t  ram_waddr, ram_raddr;
  swm_pkg::val_t   ram_wdata, ram_rdata;

  logic            in_acc, rd_more, pass_done, slot_free, full, cnt_even;
  swm_pkg::cnt_t   half;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign rd_more   = rd_idx_r < cnt_r;
  assign pass_done = !rd_more && !dvld_r;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign full      = cnt_r == swm_pkg::CNT_W'(swm_pkg::WINDOW);
  assign cnt_even  = !cnt_r[0];
  assign half      = cnt_r >> 1;

  swm_ram #(
    .WIDTH (swm_pkg::VAL_W),
    .DEPTH (swm_pkg::WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.old_present) begin
            state_nxt = swm_pkg::ST_REMOVE;
          end else if (full) begin
            state_nxt = swm_pkg::ST_MED_LO;
          end else begin
            state_nxt = swm_pkg::ST_INSERT;
          end
        end
      end
      swm_pkg::ST_REMOVE: begin
        if (pass_done) begin
          if (found_r || (ov_r != nv_r && !full)) begin
            state_nxt = swm_pkg::ST_INSERT;
          end else begin
            state_nxt = swm_pkg::ST_MED_LO;
          end
        end
      end
      swm_pkg::ST_INSERT: begin
        if (pass_done) begin
          state_nxt = swm_pkg::ST_MED_LO;
        end
      end
      swm_pkg::ST_MED_LO:  state_nxt = swm_pkg::ST_MED_HI;
      swm_pkg::ST_MED_HI:  state_nxt = swm_pkg::ST_MED_SUM;
      swm_pkg::ST_MED_SUM: begin
        if (slot_free) begin
          state_nxt = swm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    nv_nxt        = nv_r;
    ov_nxt        = ov_r;
    err_nxt       = err_r;
    rd_idx_nxt    = rd_idx_r;
    dvld_nxt      = 1'b0;
    didx_nxt      = didx_r;
    found_nxt     = found_r;
    placed_nxt    = placed_r;
    carry_nxt     = carry_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r;
    out_med_nxt   = out_med_r;
    out_cnt_nxt   = out_cnt_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = didx_r;
    ram_wdata     = carry_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r[swm_pkg::ADDR_W-1:0];

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      swm_pkg::ST_IDLE: begin
        if (in_acc) begin
          nv_nxt     = in_chan.new_value;
          ov_nxt     = in_chan.old_value;
          err_nxt    = (!in_chan.old_present && full) ? swm_pkg::ERR_FULL : swm_pkg::ERR_OK;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          placed_nxt = 1'b0;
        end
      end
      swm_pkg::ST_REMOVE: begin
        if (rd_more) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + swm_pkg::CNT_W'(1);
          dvld_nxt   = 1'b1;
          didx_nxt   = rd_idx_r[swm_pkg::ADDR_W-1:0];
        end
        if (dvld_r) begin
          if (found_r) begin
            // close the gap left by the removed entry
            ram_we    = 1'b1;
            ram_waddr = didx_r - swm_pkg::ADDR_W'(1);
            ram_wdata = ram_rdata;
          end else if (ram_rdata == ov_r) begin
            found_nxt = 1'b1;
          end
        end
        if (pass_done) begin
          rd_idx_nxt = '0;
          if (found_r) begin
            cnt_nxt = cnt_r - swm_pkg::CNT_W'(1);
          end else if (ov_r != nv_r) begin
            err_nxt = swm_pkg::ERR_NOT_FOUND;
          end
        end
      end
      swm_pkg::ST_INSERT: begin
        if (rd_more) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + swm_pkg::CNT_W'(1);
          dvld_nxt   = 1'b1;
          didx_nxt   = rd_idx_r[swm_pkg::ADDR_W-1:0];
        end
        if (dvld_r) begin
          if (placed_r) begin
            ram_we    = 1'b1;
            ram_waddr = didx_r;
            ram_wdata = carry_r;
            carry_nxt = ram_rdata;
          end else if (ram_rdata >= nv_r) begin
            ram_we     = 1'b1;
            ram_waddr  = didx_r;
            ram_wdata  = nv_r;
            carry_nxt  = ram_rdata;
            placed_nxt = 1'b1;
          end
        end
        if (pass_done) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[swm_pkg::ADDR_W-1:0];
          ram_wdata = placed_r ? carry_r : nv_r;
          cnt_nxt   = cnt_r + swm_pkg::CNT_W'(1);
        end
      end
      swm_pkg::ST_MED_LO: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_even ? swm_pkg::ADDR_W'(half - swm_pkg::CNT_W'(1))
                             : half[swm_pkg::ADDR_W-1:0];
      end
      swm_pkg::ST_MED_HI: begin
        ram_re    = 1'b1;
        ram_raddr = half[swm_pkg::ADDR_W-1:0];
        lo_nxt    = ram_rdata;
      end
      swm_pkg::ST_MED_SUM: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          out_err_nxt   = err_r;
          if (cnt_r == '0) begin
            out_med_nxt = '0;
          end else if (cnt_even) begin
            out_med_nxt = {1'b0, lo_r} + {1'b0, ram_rdata};
          end else begin
            out_med_nxt = {ram_rdata, 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swm_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      dvld_r      <= dvld_nxt;
    end
    nv_r      <= nv_nxt;
    ov_r      <= ov_nxt;
    err_r     <= err_nxt;
    rd_idx_r  <= rd_idx_nxt;
    didx_r    <= didx_nxt;
    found_r   <= found_nxt;
    placed_r  <= placed_nxt;
    carry_r   <= carry_nxt;
    lo_r      <= lo_nxt;
    out_med_r <= out_med_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_chan.ready         = state_r == swm_pkg::ST_IDLE;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.median_value = out_med_r;
  assign out_chan.stored_count = out_cnt_r;
  assign out_chan.error_code   = out_err_r;

endmodule

// ----- rtl/core/swm_chk.sv -----
module swm_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input swm_pkg::med_t out_median,
  input swm_pkg::cnt_t out_count,
  input logic [1:0]    out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in flight");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= swm_pkg::CNT_W'(swm_pkg::WINDOW))
    else $error("stored count beyond window");

  a_empty_median: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == '0 |-> out_median == '0)
    else $error("nonzero median for empty window");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error == swm_pkg::ERR_FULL
      |-> out_count == swm_pkg::CNT_W'(swm_pkg::WINDOW))
    else $error("full error without full window");

endmodule

bind sliding_window_median swm_chk u_swm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_median (out_chan.median_value),
  .out_count  (out_chan.stored_count),
  .out_error  (out_chan.error_code)
);
